// ===== design/ansi_escape_char_lcd_terminal_macros.svh =====
// Assertion macros used by the checker file of the display terminal block.
`ifndef ANSI_ESCAPE_CHAR_LCD_TERMINAL_MACROS_SVH
`define ANSI_ESCAPE_CHAR_LCD_TERMINAL_MACROS_SVH

// Consequent holds in the same cycle as the antecedent, outside reset.
`define AELCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent, outside reset.
`define AELCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent holds in the cycle after reset is seen.
`define AELCD_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== design/aelcd_pkg.sv =====
// Shared types and default sizes of the display terminal block.
package aelcd_pkg;

  localparam int LINE_WIDTH_DEF = 16;
  localparam int MAX_ARGS_DEF   = 4;

  // Which write groups one text byte causes
  typedef struct packed {
    logic lead;   // one command or character write
    logic span;   // a run of spaces
    logic trail;  // a set-address write at the final cursor
  } plan_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic emit_lead;
    logic emit_span;
    logic emit_trail;
    logic last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    plan_t now;         // plan of the byte on the input channel
    plan_t held;        // plan of the byte being worked on
    logic  span_final;  // the next space is the last of the run
  } stat_t;

endpackage

// ===== design/aelcd_if.sv =====
// Valid/ready channel interfaces for text input and display bus output.
interface aelcd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface aelcd_bus_if;
  logic       valid;
  logic       ready;
  logic       is_char;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, output is_char, output bus_byte, output last, input ready);
  modport sink (input valid, input is_char, input bus_byte, input last, output ready);
endinterface

// ===== design/ansi_escape_char_lcd_terminal.sv =====
// Top level: text stream with cursor escapes in, two-line display bus writes out.
//
// Input channel "text" carries one text byte per word; output channel "bus"
// carries one display write per word: is_char selects character data or a
// command, bus_byte holds the code, last marks the final write of a byte.
// Plain bytes make one character write while the cursor is before line end;
// ESC and ESC-[ start a sequence with up to MAX_ARGS decimal arguments,
// ended by a cursor or erase final. After a byte is accepted the sequencer
// steps through its write groups and loads the output register with one
// write per cycle while the receiver takes them; a newline or whole-line
// erase makes the most writes, LINE_WIDTH+2 of them. A new byte is taken
// once the sequencer has loaded the last write, even while that write
// still waits in the output register.
// When the receiver stalls, the output word holds and the sequencer waits.
// Synchronous reset puts the cursor at the top-left, drops any escape and
// empties the output register; there is no clearing pass.
module ansi_escape_char_lcd_terminal #(
  parameter int LINE_WIDTH = aelcd_pkg::LINE_WIDTH_DEF,
  parameter int MAX_ARGS   = aelcd_pkg::MAX_ARGS_DEF
) (
  input logic         clk,
  input logic         rst,
  aelcd_text_if.sink  text,
  aelcd_bus_if.source bus
);

  aelcd_pkg::cmd_t  cmd;
  aelcd_pkg::stat_t stat;

  aelcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .out_ready (bus.ready),
    .stat      (stat),
    .in_ready  (text.ready),
    .out_valid (bus.valid),
    .cmd       (cmd)
  );

  aelcd_dp #(
    .LINE_WIDTH (LINE_WIDTH),
    .MAX_ARGS   (MAX_ARGS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text.text_byte),
    .cmd       (cmd),
    .stat      (stat),
    .is_char   (bus.is_char),
    .bus_byte  (bus.bus_byte),
    .last      (bus.last)
  );

endmodule

// ===== design/aelcd_dp.sv =====
// Datapath: escape parser, cursor and argument state, write planning and output word.
module aelcd_dp #(
  parameter int LINE_WIDTH = aelcd_pkg::LINE_WIDTH_DEF,
  parameter int MAX_ARGS   = aelcd_pkg::MAX_ARGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        text_byte,
  input  aelcd_pkg::cmd_t   cmd,
  output aelcd_pkg::stat_t  stat,
  output logic              is_char,
  output logic [7:0]        bus_byte,
  output logic              last
);

  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam int IW = $clog2(MAX_ARGS);
  localparam logic [CW-1:0] LW       = CW'(LINE_WIDTH);
  localparam logic [8:0]    LW9      = 9'(LINE_WIDTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_ARGS - 1);

  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_0         = "0";
  localparam logic [7:0] CH_9         = "9";
  localparam logic [7:0] CH_SEMI      = ";";
  localparam logic [7:0] CH_LBRACK    = "[";
  localparam logic [7:0] CH_UP        = "A";
  localparam logic [7:0] CH_DOWN      = "B";
  localparam logic [7:0] CH_FWD       = "C";
  localparam logic [7:0] CH_BACK      = "D";
  localparam logic [7:0] CH_NEXT_LN   = "E";
  localparam logic [7:0] CH_PREV_LN   = "F";
  localparam logic [7:0] CH_COL_ABS   = "G";
  localparam logic [7:0] CH_HOME      = "H";
  localparam logic [7:0] CH_HOME_ALT  = "f";
  localparam logic [7:0] CH_CLEAR     = "J";
  localparam logic [7:0] CH_ERASE     = "K";
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ARG_MAX      = 8'hFF;
  localparam logic [6:0] ROW1_BASE    = 7'h40;
  localparam logic [6:0] ROW0_BASE    = 7'h00;

  typedef enum logic [1:0] {MODE_NONE, MODE_ESC, MODE_SEQ} mode_t;

  // Cursor and parser state
  mode_t         mode;
  logic          row;
  logic [CW-1:0] col;
  logic [7:0]    args [MAX_ARGS];
  logic [IW-1:0] arg_idx;

  // Work of the current byte
  aelcd_pkg::plan_t plan;
  logic [7:0]       lead_byte;
  logic             lead_char;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    span_end;

  mode_t            mode_next;
  logic             row_next;
  logic [CW-1:0]    col_next;
  logic [7:0]       args_next [MAX_ARGS];
  logic [IW-1:0]    arg_idx_next;
  aelcd_pkg::plan_t plan_next;
  logic [7:0]       lead_byte_next;
  logic             lead_char_next;
  logic [CW-1:0]    pos_next;
  logic [CW-1:0]    span_end_next;

  function automatic logic [CW-1:0] clamp_col(input logic [8:0] v);
    return (v > LW9) ? LW : CW'(v);
  endfunction

  function automatic logic [7:0] addr_cmd(input logic r, input logic [CW-1:0] c);
    logic [6:0] base;
    base = r ? ROW1_BASE : ROW0_BASE;
    return {1'b1, base + 7'(c)};
  endfunction

  // Argument and column arithmetic
  logic          seq;
  logic [7:0]    a0;
  logic          a0_nz;
  logic [7:0]    step;
  logic [8:0]    sum_fwd;
  logic [CW-1:0] col_fwd;
  logic [CW-1:0] col_back;
  logic [CW-1:0] col_abs;
  logic [CW-1:0] col_home;
  logic          home_col_open;
  logic [7:0]    arg_cur;
  logic [11:0]   arg_acc;
  logic [7:0]    arg_sat;

  assign seq      = (mode == MODE_SEQ);
  assign a0       = seq ? args[0] : 8'd0;
  assign a0_nz    = (a0 != 8'd0);
  assign step     = a0_nz ? a0 : 8'd1;
  assign sum_fwd  = 9'(col) + 9'(step);
  assign col_fwd  = clamp_col(sum_fwd);
  assign col_back = (9'(col) >= 9'(step)) ? CW'(9'(col) - 9'(step)) : '0;
  assign col_abs  = a0_nz ? clamp_col(9'(a0 - 8'd1)) : '0;
  assign home_col_open = seq && (arg_idx != '0) && (args[1] != 8'd0);
  assign col_home = home_col_open ? clamp_col(9'(args[1] - 8'd1)) : '0;
  assign arg_cur  = args[arg_idx];
  assign arg_acc  = 12'({arg_cur, 3'b000}) + 12'({arg_cur, 1'b0}) + 12'(text_byte[3:0]);
  assign arg_sat  = (arg_acc > 12'(ARG_MAX)) ? ARG_MAX : arg_acc[7:0];

  // Decode the byte on the input channel into next state and write plan
  always_comb begin
    mode_next      = mode;
    row_next       = row;
    col_next       = col;
    for (int i = 0; i < MAX_ARGS; i++) begin
      args_next[i] = args[i];
    end
    arg_idx_next   = arg_idx;
    plan_next      = '0;
    lead_byte_next = lead_byte;
    lead_char_next = 1'b0;
    pos_next       = pos;
    span_end_next  = span_end;

    if (mode != MODE_NONE) begin
      unique case (text_byte) inside
        [CH_0:CH_9]: begin
          if (seq) begin
            args_next[arg_idx] = arg_sat;
          end else begin
            mode_next = MODE_NONE;
          end
        end
        CH_SEMI: begin
          if (seq) begin
            if (arg_idx < IDX_LAST) begin
              arg_idx_next = arg_idx + 1'b1;
              args_next[IW'(arg_idx + 1'b1)] = 8'd0;
            end
          end else begin
            mode_next = MODE_NONE;
          end
        end
        CH_LBRACK: begin
          arg_idx_next = '0;
          args_next[0] = 8'd0;
          mode_next    = MODE_SEQ;
        end
        CH_UP, CH_DOWN, CH_NEXT_LN, CH_PREV_LN: begin
          mode_next = MODE_NONE;
          if (text_byte == CH_NEXT_LN || text_byte == CH_PREV_LN) begin
            col_next = '0;
          end
          row_next       = a0_nz ? (row ^ a0[0]) : ~row;
          plan_next.lead = 1'b1;
          lead_byte_next = addr_cmd(row_next, col_next);
        end
        CH_FWD: begin
          mode_next      = MODE_NONE;
          col_next       = col_fwd;
          plan_next.lead = 1'b1;
          lead_byte_next = addr_cmd(row, col_fwd);
        end
        CH_BACK: begin
          mode_next      = MODE_NONE;
          col_next       = col_back;
          plan_next.lead = 1'b1;
          lead_byte_next = addr_cmd(row, col_back);
        end
        CH_COL_ABS: begin
          mode_next      = MODE_NONE;
          col_next       = col_abs;
          plan_next.lead = 1'b1;
          lead_byte_next = addr_cmd(row, col_abs);
        end
        CH_HOME, CH_HOME_ALT: begin
          mode_next      = MODE_NONE;
          col_next       = col_home;
          row_next       = a0_nz ? (a0 != 8'd1) : 1'b0;
          plan_next.lead = 1'b1;
          lead_byte_next = addr_cmd(row_next, col_home);
        end
        CH_CLEAR: begin
          mode_next      = MODE_NONE;
          plan_next.lead = 1'b1;
          lead_byte_next = CMD_CLEAR;
        end
        CH_ERASE: begin
          mode_next = MODE_NONE;
          if (a0 == 8'd1) begin
            // Blank from line start up to the cursor
            plan_next.lead = 1'b1;
            plan_next.span = (col != '0);
            lead_byte_next = addr_cmd(row, '0);
            pos_next       = '0;
            span_end_next  = col;
          end else if (a0 == 8'd2) begin
            // Blank the whole line, then return to the cursor
            plan_next.lead  = 1'b1;
            plan_next.span  = 1'b1;
            plan_next.trail = 1'b1;
            lead_byte_next  = addr_cmd(row, '0);
            pos_next        = '0;
            span_end_next   = LW;
          end else begin
            // Blank from the cursor to line end, then return
            plan_next.span  = (col != LW);
            plan_next.trail = 1'b1;
            pos_next        = col;
            span_end_next   = LW;
          end
        end
        default: begin
          mode_next = MODE_NONE;
        end
      endcase
    end else if (text_byte == CH_ESC) begin
      mode_next = MODE_ESC;
    end else if (text_byte == CH_NEWLINE) begin
      // Move to the other line and blank it
      row_next        = ~row;
      col_next        = '0;
      plan_next.lead  = 1'b1;
      plan_next.span  = 1'b1;
      plan_next.trail = 1'b1;
      lead_byte_next  = addr_cmd(~row, '0);
      pos_next        = '0;
      span_end_next   = LW;
    end else if (col < LW) begin
      col_next       = col + 1'b1;
      plan_next.lead = 1'b1;
      lead_char_next = 1'b1;
      lead_byte_next = text_byte;
    end
  end

  // Control state: update on an accepted byte, advance the space pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NONE;
      row     <= 1'b0;
      col     <= '0;
      for (int i = 0; i < MAX_ARGS; i++) begin
        args[i] <= 8'd0;
      end
      arg_idx <= '0;
      plan    <= '0;
      pos     <= '0;
    end else if (cmd.take) begin
      mode    <= mode_next;
      row     <= row_next;
      col     <= col_next;
      args    <= args_next;
      arg_idx <= arg_idx_next;
      plan    <= plan_next;
      pos     <= pos_next;
    end else if (cmd.emit_span) begin
      pos <= pos + 1'b1;
    end
  end

  // Payload of the current byte's work
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lead_byte <= lead_byte_next;
      lead_char <= lead_char_next;
      span_end  <= span_end_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.emit_lead) begin
      is_char  <= lead_char;
      bus_byte <= lead_byte;
      last     <= cmd.last;
    end else if (cmd.emit_span) begin
      is_char  <= 1'b1;
      bus_byte <= CH_SPACE;
      last     <= cmd.last;
    end else if (cmd.emit_trail) begin
      is_char  <= 1'b0;
      bus_byte <= addr_cmd(row, col);
      last     <= cmd.last;
    end
  end

  assign stat.now        = plan_next;
  assign stat.held       = plan;
  assign stat.span_final = (CW'(pos + 1'b1) == span_end);

endmodule

// ===== design/aelcd_ctrl.sv =====
// Controller: sequences the lead write, the space run and the trailing address write.
module aelcd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  aelcd_pkg::stat_t stat,
  output logic             in_ready,
  output logic             out_valid,
  output aelcd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_LEAD, ST_SPAN, ST_TRAIL} state_t;

  state_t state;
  state_t state_next;
  logic   free;
  logic   emitting;

  assign free     = !out_valid || out_ready;
  assign emitting = cmd.emit_lead || cmd.emit_span || cmd.emit_trail;
  assign in_ready = (state == ST_IDLE);

  // Pick the next write group and issue one word per free cycle
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.now.lead) begin
            state_next = ST_LEAD;
          end else if (stat.now.span) begin
            state_next = ST_SPAN;
          end else if (stat.now.trail) begin
            state_next = ST_TRAIL;
          end
        end
      end
      ST_LEAD: begin
        if (free) begin
          cmd.emit_lead = 1'b1;
          cmd.last      = !stat.held.span && !stat.held.trail;
          if (stat.held.span) begin
            state_next = ST_SPAN;
          end else if (stat.held.trail) begin
            state_next = ST_TRAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SPAN: begin
        if (free) begin
          cmd.emit_span = 1'b1;
          cmd.last      = stat.span_final && !stat.held.trail;
          if (stat.span_final) begin
            state_next = stat.held.trail ? ST_TRAIL : ST_IDLE;
          end
        end
      end
      ST_TRAIL: begin
        if (free) begin
          cmd.emit_trail = 1'b1;
          cmd.last       = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emitting) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/aelcd_check.sv =====
// Port-level checker of the display terminal block and its bind.
`include "ansi_escape_char_lcd_terminal_macros.svh"

module aelcd_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_char,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled word keeps its payload
  `AELCD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_is_char) && $stable(out_last), "output word changed while stalled")

  // No new byte is taken while the current byte still has writes to come
  `AELCD_ASSERT_SAME(a_busy_until_last, clk, rst, out_valid && !out_last, !in_ready, "input ready before the last write of a byte")

  // A byte is taken only with an empty output or a final write in it
  `AELCD_ASSERT_SAME(a_take_idle, clk, rst, in_valid && in_ready, !out_valid || out_last, "early take")

  // Reset leaves an empty output and a ready input
  `AELCD_ASSERT_RESET(a_reset_state, clk, rst, !out_valid && in_ready, "bad state after reset")

endmodule

bind ansi_escape_char_lcd_terminal aelcd_check u_aelcd_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text.valid),
  .in_ready    (text.ready),
  .out_valid   (bus.valid),
  .out_ready   (bus.ready),
  .out_is_char (bus.is_char),
  .out_byte    (bus.bus_byte),
  .out_last    (bus.last)
);
